// ----- sv/ue8_pkg.sv -----
// Shared types and constants for the escape-to-UTF-8 converter.
package ue8_pkg;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_U   = 8'h75;

    localparam logic [15:0] LIM_1B = 16'h007F;
    localparam logic [15:0] LIM_2B = 16'h07FF;
    localparam logic [7:0]  LEAD_2B = 8'hC0;
    localparam logic [7:0]  LEAD_3B = 8'hE0;
    localparam logic [7:0]  CONT_B  = 8'h80;
    localparam logic [7:0]  CONT_MASK = 8'h3F;

    localparam int NBYTES     = 5;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BSL,
        PH_U,
        PH_H1,
        PH_H2,
        PH_H3
    } t_phase;

    typedef enum logic {
        CMD_RAW,
        CMD_UTF8
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic [2:0]              cnt;
        logic                    last;
        logic [NBYTES-1:0][7:0]  bytes;
        logic [15:0]             value;
    } t_cmd;

endpackage

// ----- sv/ue8_front.sv -----
// Front end: parses escapes and turns each request into at most one output command.
module ue8_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    output logic          o_push,
    output ue8_pkg::t_cmd o_cmd
);

    ue8_pkg::t_phase   r_phase, n_phase;
    logic [2:0][7:0]   r_held, n_held;
    logic [15:0]       r_hex, n_hex;
    logic              r_open, n_open;

    logic              hex_ok;
    logic [3:0]        hex_d;
    logic [15:0]       fed_hex;
    logic              fed_open;
    ue8_pkg::t_cmd     cmd;

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (i_in_byte >= 8'h30 && i_in_byte <= 8'h39) begin
            hex_d = 4'(i_in_byte - 8'h30);
        end else if (i_in_byte >= 8'h61 && i_in_byte <= 8'h66) begin
            hex_d = 4'(i_in_byte - 8'h57);
        end else if (i_in_byte >= 8'h41 && i_in_byte <= 8'h46) begin
            hex_d = 4'(i_in_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
        fed_open = r_open && hex_ok;
        fed_hex  = fed_open ? {r_hex[11:0], hex_d} : r_hex;
    end

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_hex   = r_hex;
        n_open  = r_open;
        cmd     = '0;
        cmd.kind = ue8_pkg::CMD_RAW;
        cmd.last = i_in_last;

        unique case (r_phase)
            ue8_pkg::PH_BSL: begin
                if (i_in_byte == ue8_pkg::CH_U) begin
                    n_phase = ue8_pkg::PH_U;
                    n_hex   = '0;
                    n_open  = 1'b1;
                end else begin
                    cmd.bytes[0] = ue8_pkg::CH_BSL;
                    cmd.cnt      = 3'd1;
                    if (i_in_byte != ue8_pkg::CH_BSL) begin
                        n_phase      = ue8_pkg::PH_IDLE;
                        cmd.bytes[1] = i_in_byte;
                        cmd.cnt      = 3'd2;
                    end
                end
            end
            ue8_pkg::PH_U: begin
                n_hex     = fed_hex;
                n_open    = fed_open;
                n_held[0] = i_in_byte;
                n_phase   = ue8_pkg::PH_H1;
            end
            ue8_pkg::PH_H1: begin
                n_hex     = fed_hex;
                n_open    = fed_open;
                n_held[1] = i_in_byte;
                n_phase   = ue8_pkg::PH_H2;
            end
            ue8_pkg::PH_H2: begin
                n_hex     = fed_hex;
                n_open    = fed_open;
                n_held[2] = i_in_byte;
                n_phase   = ue8_pkg::PH_H3;
            end
            ue8_pkg::PH_H3: begin
                cmd.kind  = ue8_pkg::CMD_UTF8;
                cmd.value = fed_hex;
                if (fed_hex <= ue8_pkg::LIM_1B) begin
                    cmd.cnt = 3'd1;
                end else if (fed_hex <= ue8_pkg::LIM_2B) begin
                    cmd.cnt = 3'd2;
                end else begin
                    cmd.cnt = 3'd3;
                end
                n_phase = ue8_pkg::PH_IDLE;
                n_hex   = '0;
                n_open  = 1'b1;
            end
            default: begin
                if (i_in_byte == ue8_pkg::CH_BSL) begin
                    n_phase = ue8_pkg::PH_BSL;
                end else begin
                    n_phase      = ue8_pkg::PH_IDLE;
                    cmd.bytes[0] = i_in_byte;
                    cmd.cnt      = 3'd1;
                end
            end
        endcase

        if (i_in_last) begin
            // A partial escape at the end of the string leaves as raw text.
            unique case (n_phase)
                ue8_pkg::PH_BSL: begin
                    if (cmd.cnt == 3'd0) begin
                        cmd.bytes[0] = ue8_pkg::CH_BSL;
                        cmd.cnt      = 3'd1;
                    end else begin
                        cmd.bytes[1] = ue8_pkg::CH_BSL;
                        cmd.cnt      = 3'd2;
                    end
                end
                ue8_pkg::PH_U, ue8_pkg::PH_H1, ue8_pkg::PH_H2, ue8_pkg::PH_H3: begin
                    cmd.bytes = {n_held[2], n_held[1], n_held[0],
                                 ue8_pkg::CH_U, ue8_pkg::CH_BSL};
                    unique case (n_phase)
                        ue8_pkg::PH_U:  cmd.cnt = 3'd2;
                        ue8_pkg::PH_H1: cmd.cnt = 3'd3;
                        ue8_pkg::PH_H2: cmd.cnt = 3'd4;
                        default:        cmd.cnt = 3'd5;
                    endcase
                end
                default: begin
                end
            endcase
            n_phase = ue8_pkg::PH_IDLE;
            n_hex   = '0;
            n_open  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ue8_pkg::PH_IDLE;
            r_hex   <= '0;
            r_open  <= 1'b1;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_open  <= n_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_held <= n_held;
        end
    end

    assign o_push = i_valid && (cmd.cnt != 3'd0);
    assign o_cmd  = cmd;

endmodule

// ----- sv/ue8_fifo.sv -----
// Short command queue between the front end and the back end.
module ue8_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ue8_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output ue8_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW = (ue8_pkg::FIFO_DEPTH > 1) ? $clog2(ue8_pkg::FIFO_DEPTH) : 1;
    localparam int CW = $clog2(ue8_pkg::FIFO_DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(ue8_pkg::FIFO_DEPTH - 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(ue8_pkg::FIFO_DEPTH);

    ue8_pkg::t_cmd   r_mem [ue8_pkg::FIFO_DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign do_push = i_push && (r_cnt != CNT_MAX);
    assign do_pop  = i_pop && (r_cnt != '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_MAX) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_MAX) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd];
    assign o_full  = (r_cnt == CNT_MAX);
    assign o_empty = (r_cnt == '0);

endmodule

// ----- sv/ue8_back.sv -----
// Back end: expands the command at the queue head into output bytes.
module ue8_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ue8_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    input  logic          i_pop,
    output logic          o_fifo_pop,
    output logic [7:0]    o_out_byte,
    output logic          o_out_last
);

    logic [2:0] r_idx, n_idx;
    logic       at_end;
    logic [7:0] raw_b;
    logic [7:0] enc_b;

    assign at_end = (r_idx == i_cmd.cnt - 3'd1);

    always_comb begin
        unique case (r_idx)
            3'd0:    raw_b = i_cmd.bytes[0];
            3'd1:    raw_b = i_cmd.bytes[1];
            3'd2:    raw_b = i_cmd.bytes[2];
            3'd3:    raw_b = i_cmd.bytes[3];
            default: raw_b = i_cmd.bytes[4];
        endcase
    end

    always_comb begin
        enc_b = i_cmd.value[7:0];
        if (i_cmd.cnt == 3'd2) begin
            if (r_idx == 3'd0) begin
                enc_b = ue8_pkg::LEAD_2B | {3'd0, i_cmd.value[10:6]};
            end else begin
                enc_b = ue8_pkg::CONT_B | (i_cmd.value[7:0] & ue8_pkg::CONT_MASK);
            end
        end else if (i_cmd.cnt == 3'd3) begin
            if (r_idx == 3'd0) begin
                enc_b = ue8_pkg::LEAD_3B | {4'd0, i_cmd.value[15:12]};
            end else if (r_idx == 3'd1) begin
                enc_b = ue8_pkg::CONT_B | (i_cmd.value[13:6] & ue8_pkg::CONT_MASK);
            end else begin
                enc_b = ue8_pkg::CONT_B | (i_cmd.value[7:0] & ue8_pkg::CONT_MASK);
            end
        end
    end

    always_comb begin
        n_idx      = r_idx;
        o_fifo_pop = 1'b0;
        if (i_pop && !i_empty) begin
            if (at_end) begin
                n_idx      = '0;
                o_fifo_pop = 1'b1;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    assign o_out_byte = (i_cmd.kind == ue8_pkg::CMD_UTF8) ? enc_b : raw_b;
    assign o_out_last = i_cmd.last && at_end;

endmodule

// ----- sv/unicode_escape_to_utf8.sv -----
// Top level of the escape-to-UTF-8 converter.
//
// Channel   Direction  Handshake         Payload
// input     in         push / full       i_in_byte, i_in_last
// result    out        empty / pop       o_out_byte, o_out_last
//
// The front end takes one request per cycle while the queue is not full, and turns
// it into at most one command. A two-entry command queue separates it from the
// back end. The back end delivers one byte per cycle while pop is high and the
// queue is not empty; a full escape takes six bytes in and gives up to three out.
// Reset is synchronous and active low and empties the queue and the parser state.
// A stalled result holds while the front end keeps filling the queue.
module unicode_escape_to_utf8 (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic          accept;
    logic          cmd_push;
    logic          cmd_pop;
    ue8_pkg::t_cmd cmd_in;
    ue8_pkg::t_cmd cmd_head;

    assign accept = push && !full;

    ue8_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_push    (cmd_push),
        .o_cmd     (cmd_in)
    );

    ue8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_head),
        .o_full  (full),
        .o_empty (empty)
    );

    ue8_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_head),
        .i_empty    (empty),
        .i_pop      (pop),
        .o_fifo_pop (cmd_pop),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule

// ----- sv/ue8_checker.sv -----
// Port-level checks for the escape-to-UTF-8 converter and their binding.
module ue8_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_out_byte,
    input logic       o_out_last
);

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !full && empty)
        else $error("Queue not empty after reset.");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("Queue reports full and empty at once.");

    a_stay_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty && !(push && !full) |=> empty)
        else $error("Result appeared without a request.");

    a_stay_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full && !pop |=> full)
        else $error("Queue drained without a pop.");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_out_last))
        else $error("Stalled result changed.");

endmodule

bind unicode_escape_to_utf8 ue8_checker u_ue8_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_byte (o_out_byte),
    .o_out_last (o_out_last)
);

// ----- tb/unicode_escape_to_utf8_tb.sv -----
// Self-checking testbench for the escape-to-UTF-8 converter with directed and random text.
module unicode_escape_to_utf8_tb;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_CHARS = 300;

    typedef struct {
        logic [7:0] data;
        logic       eos;
    } t_text_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_in_last = 1'b0;
    logic       pop = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    t_text_char text_pending[$];
    t_text_char utf8_expected[$];
    logic [7:0] text_buf[$];
    logic [7:0] step_bytes[$];

    ue8_pkg::t_phase esc_phase = ue8_pkg::PH_IDLE;
    logic [7:0]      esc_held[4];
    logic [15:0]     esc_value = 16'h0000;
    logic            esc_run_open = 1'b1;

    int   n_fail = 0;
    int   n_accepted = 0;
    int   cycle_cnt = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   rx_cycle = 0;
    int   rx_mode = 0;
    logic hold_off = 1'b0;

    unicode_escape_to_utf8 dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .empty      (empty),
        .pop        (pop),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] nib);
        nib = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            nib = c[3:0];
            return 1'b1;
        end
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            nib = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10) begin
            return 8'h30 + 8'(nib);
        end
        return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
    endfunction

    task automatic take_hex_char(input logic [7:0] c);
        logic [3:0] nib;
        if (esc_run_open && hex_nibble(c, nib)) begin
            esc_value = {esc_value[11:0], nib};
        end else begin
            esc_run_open = 1'b0;
        end
    endtask

    task automatic emit_utf8(input logic [15:0] v);
        if (v <= ue8_pkg::LIM_1B) begin
            step_bytes.push_back(v[7:0]);
        end else if (v <= ue8_pkg::LIM_2B) begin
            step_bytes.push_back(ue8_pkg::LEAD_2B | 8'(v >> 6));
            step_bytes.push_back(ue8_pkg::CONT_B | (v[7:0] & ue8_pkg::CONT_MASK));
        end else begin
            step_bytes.push_back(ue8_pkg::LEAD_3B | 8'(v >> 12));
            step_bytes.push_back(ue8_pkg::CONT_B | (8'(v >> 6) & ue8_pkg::CONT_MASK));
            step_bytes.push_back(ue8_pkg::CONT_B | (v[7:0] & ue8_pkg::CONT_MASK));
        end
    endtask

    task automatic predict_step(input logic [7:0] b, input logic eos);
        t_text_char r;
        step_bytes.delete();
        case (esc_phase)
            ue8_pkg::PH_BSL: begin
                if (b == ue8_pkg::CH_U) begin
                    esc_phase = ue8_pkg::PH_U;
                    esc_value = 16'h0000;
                    esc_run_open = 1'b1;
                end else begin
                    step_bytes.push_back(ue8_pkg::CH_BSL);
                    if (b == ue8_pkg::CH_BSL) begin
                        esc_phase = ue8_pkg::PH_BSL;
                    end else begin
                        esc_phase = ue8_pkg::PH_IDLE;
                        step_bytes.push_back(b);
                    end
                end
            end
            ue8_pkg::PH_U, ue8_pkg::PH_H1, ue8_pkg::PH_H2: begin
                take_hex_char(b);
                esc_held[esc_phase - ue8_pkg::PH_U] = b;
                esc_phase = ue8_pkg::t_phase'(esc_phase + 1);
            end
            ue8_pkg::PH_H3: begin
                take_hex_char(b);
                emit_utf8(esc_value);
                esc_phase = ue8_pkg::PH_IDLE;
                esc_value = 16'h0000;
                esc_run_open = 1'b1;
            end
            default: begin
                if (b == ue8_pkg::CH_BSL) begin
                    esc_phase = ue8_pkg::PH_BSL;
                end else begin
                    esc_phase = ue8_pkg::PH_IDLE;
                    step_bytes.push_back(b);
                end
            end
        endcase
        if (eos) begin
            if (esc_phase != ue8_pkg::PH_IDLE) begin
                step_bytes.push_back(ue8_pkg::CH_BSL);
            end
            if (esc_phase >= ue8_pkg::PH_U) begin
                step_bytes.push_back(ue8_pkg::CH_U);
                for (int k = 0; k < esc_phase - ue8_pkg::PH_U; k++) begin
                    step_bytes.push_back(esc_held[k]);
                end
            end
            esc_phase = ue8_pkg::PH_IDLE;
            esc_value = 16'h0000;
            esc_run_open = 1'b1;
        end
        foreach (step_bytes[k]) begin
            r.data = step_bytes[k];
            r.eos = eos && (k == step_bytes.size() - 1);
            utf8_expected.push_back(r);
        end
    endtask

    task automatic add_ascii(input string s);
        for (int k = 0; k < s.len(); k++) begin
            text_buf.push_back(8'(s[k]));
        end
    endtask

    task automatic close_text();
        t_text_char r;
        foreach (text_buf[k]) begin
            r.data = text_buf[k];
            r.eos = (k == text_buf.size() - 1);
            text_pending.push_back(r);
        end
        text_buf.delete();
    endtask

    always @(posedge i_clk) begin : request_driver
        t_text_char nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                predict_step(i_in_byte, i_in_last);
                n_accepted++;
            end
            if (!(push && full)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (text_pending.size() > 0) begin
                    nxt = text_pending.pop_front();
                    push <= 1'b1;
                    i_in_byte <= nxt.data;
                    i_in_last <= nxt.eos;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_text_char want;
        logic       ready;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (utf8_expected.size() == 0) begin
                    $error("out_byte: no result expected, got %h", o_out_byte);
                    n_fail++;
                end else begin
                    want = utf8_expected.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %h, got %h", want.data, o_out_byte);
                        n_fail++;
                    end
                    if (o_out_last !== want.eos) begin
                        $error("out_last: expected %b, got %b", want.eos, o_out_last);
                        n_fail++;
                    end
                end
            end
            rx_cycle++;
            if (rx_cycle % 50 == 0) begin
                rx_mode = $urandom_range(0, 3);
            end
            case (rx_mode)
                0: ready = 1'b1;
                1: ready = 1'($urandom_range(0, 1));
                2: ready = (rx_cycle % 4 == 0);
                default: ready = ($urandom_range(0, 3) != 0);
            endcase
            pop <= ready && !hold_off;
        end
    end

    // The receiver stops for a long stretch so the block fills and pushes back.
    initial begin
        wait (n_accepted >= 60);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : text_source
        int          nseg;
        int          kind;
        int          span;
        logic [15:0] v;
        bit          stop;

        text_buf = '{8'h00, 8'hFF};
        close_text();
        add_ascii("\\\\u07fF");
        close_text();
        add_ascii("\\uD800");
        close_text();
        add_ascii("\\uz\\12");
        close_text();
        add_ascii("\\u1");
        close_text();
        add_ascii("\\x\\");
        close_text();

        while (text_pending.size() < 27 + RANDOM_CHARS) begin
            nseg = $urandom_range(1, 8);
            stop = 1'b0;
            for (int s = 0; s < nseg && !stop; s++) begin
                kind = $urandom_range(0, 9);
                if (kind <= 3) begin
                    text_buf.push_back(8'($urandom_range(0, 255)));
                end else if (kind <= 6) begin
                    case ($urandom_range(0, 2))
                        0: v = 16'($urandom_range(0, 16'h007F));
                        1: v = 16'($urandom_range(16'h0080, 16'h07FF));
                        default: v = 16'($urandom_range(16'h0800, 16'hFFFF));
                    endcase
                    text_buf.push_back(ue8_pkg::CH_BSL);
                    text_buf.push_back(ue8_pkg::CH_U);
                    for (int i = 3; i >= 0; i--) begin
                        text_buf.push_back(hex_char(v[4*i +: 4], 1'($urandom_range(0, 1))));
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        text_buf[text_buf.size() - 1 - $urandom_range(0, 3)] =
                            8'($urandom_range(0, 255));
                    end
                end else if (kind == 7) begin
                    text_buf.push_back(ue8_pkg::CH_BSL);
                    text_buf.push_back(8'($urandom_range(0, 255)));
                end else if (kind == 8) begin
                    text_buf.push_back(ue8_pkg::CH_BSL);
                    if ($urandom_range(0, 3) != 0) begin
                        text_buf.push_back(ue8_pkg::CH_U);
                        span = $urandom_range(0, 3);
                        repeat (span) text_buf.push_back(hex_char(4'($urandom_range(0, 15)), 1'b0));
                    end
                    stop = 1'b1;
                end else begin
                    span = $urandom_range(1, 3);
                    repeat (span) text_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            close_text();
        end

        @(posedge i_clk);
        while (text_pending.size() != 0 || push || utf8_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- unicode_escape_to_utf8.f -----
sv/ue8_pkg.sv
sv/ue8_front.sv
sv/ue8_fifo.sv
sv/ue8_back.sv
sv/unicode_escape_to_utf8.sv
sv/ue8_checker.sv
tb/unicode_escape_to_utf8_tb.sv
